### hw/rtl/palette_nearest_color_unit_defines.svh
// assertion macros for the palette nearest colour unit
`ifndef PALETTE_NEAREST_COLOR_UNIT_DEFINES_SVH
`define PALETTE_NEAREST_COLOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define PNC_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("palette nearest colour unit check failed");
`define PNC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) ante |=> cons) \
        else $error("palette nearest colour unit sequencing check failed");
`else
`define PNC_ASSERT(label, prop)
`define PNC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### hw/rtl/pnc_pkg.sv
package pnc_pkg;

    localparam int MAX_ENTRIES_DEF = 256;
    localparam int MODE_W          = 2;
    localparam int IDX_W           = 8;
    localparam int COLOR_W         = 24;
    localparam int SIZE_W          = 9;
    localparam int DIST_W          = 10;
    localparam int SIZE_RESET      = 256;

    localparam logic [DIST_W-1:0] DIST_INIT = '1;

    typedef enum logic [MODE_W-1:0] {
        MODE_WRITE = 2'd0,
        MODE_READ  = 2'd1,
        MODE_FIND  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RD_OUT,
        S_FIND_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic mem_wr;
        logic mem_rd;
        logic start;
        logic scan;
        logic load_out;
        logic out_find;
    } t_dp_cmd;

    typedef struct packed {
        logic in_range;
        logic scan_done;
        logic out_free;
    } t_dp_sts;

    function automatic logic [DIST_W-1:0] color_dist(input logic [COLOR_W-1:0] a,
                                                    input logic [COLOR_W-1:0] b);
        logic [7:0]        x;
        logic [7:0]        y;
        logic [DIST_W-1:0] d;
        d = '0;
        for (int ch = 0; ch < 3; ch++) begin
            x = a[ch*8 +: 8];
            y = b[ch*8 +: 8];
            d = d + DIST_W'((x > y) ? (x - y) : (y - x));
        end
        return d;
    endfunction

endpackage

### hw/rtl/pnc_req_if.sv
interface pnc_req_if;
    import pnc_pkg::*;

    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [IDX_W-1:0]    entry_index;
    logic [COLOR_W-1:0]  color_in;

    modport source (output valid, output mode, output entry_index, output color_in,
                    input ready);
    modport sink   (input valid, input mode, input entry_index, input color_in,
                    output ready);
endinterface

### hw/rtl/pnc_res_if.sv
interface pnc_res_if;
    import pnc_pkg::*;

    logic                valid;
    logic                ready;
    logic [IDX_W-1:0]    best_index;
    logic [COLOR_W-1:0]  color_out;
    logic                valid_res;

    modport source (output valid, output best_index, output color_out, output valid_res,
                    input ready);
    modport sink   (input valid, input best_index, input color_out, input valid_res,
                    output ready);
endinterface

### hw/rtl/pnc_cfg_if.sv
interface pnc_cfg_if;
    import pnc_pkg::*;

    logic               valid;
    logic               ready;
    logic [SIZE_W-1:0]  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/pnc_ctrl.sv
module pnc_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic [pnc_pkg::MODE_W-1:0]  i_mode,
    input  pnc_pkg::t_dp_sts            i_sts,
    output logic                        o_in_ready,
    output pnc_pkg::t_dp_cmd            o_cmd
);
    import pnc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    case (t_mode'(i_mode))
                        MODE_WRITE: begin
                            o_cmd.mem_wr = i_sts.in_range;
                        end
                        MODE_READ: begin
                            o_cmd.mem_rd = 1'b1;
                            n_state      = S_RD_OUT;
                        end
                        MODE_FIND: begin
                            o_cmd.start = 1'b1;
                            n_state     = S_SCAN;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_FIND_OUT;
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            S_RD_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_FIND_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.out_find = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/pnc_datapath.sv
module pnc_datapath #(
    parameter int MAX_ENTRIES = pnc_pkg::MAX_ENTRIES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pnc_pkg::t_dp_cmd             i_cmd,
    output pnc_pkg::t_dp_sts             o_sts,
    input  logic                         i_cfg_valid,
    input  logic [pnc_pkg::SIZE_W-1:0]   i_cfg_data,
    input  logic [pnc_pkg::IDX_W-1:0]    i_entry_index,
    input  logic [pnc_pkg::COLOR_W-1:0]  i_color_in,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [pnc_pkg::IDX_W-1:0]    o_best_index,
    output logic [pnc_pkg::COLOR_W-1:0]  o_color_out,
    output logic                         o_valid_res
);
    import pnc_pkg::*;

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    logic [COLOR_W-1:0] mem [MAX_ENTRIES];

    logic [SIZE_W-1:0]  r_size;
    logic [SIZE_W-1:0]  size_eff;
    logic               in_range;

    logic [IDX_W-1:0]   r_idx;
    logic               r_ok;
    logic [COLOR_W-1:0] r_target;
    logic [CW-1:0]      r_n;

    logic [CW-1:0]      r_cnt;
    logic               r_pend;
    logic [AW-1:0]      r_pend_idx;
    logic [AW-1:0]      r_best;
    logic [DIST_W-1:0]  r_bestd;
    logic [COLOR_W-1:0] r_rd_data;

    logic               issue;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [DIST_W-1:0]  cur_dist;

    logic               r_out_valid;
    logic [IDX_W-1:0]   r_out_idx;
    logic [COLOR_W-1:0] r_out_color;
    logic               r_out_ok;

    // palette size register, values above the store depth clamp to it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_W'(SIZE_RESET);
        end else if (i_cfg_valid) begin
            r_size <= i_cfg_data;
        end
    end

    assign size_eff = (r_size > SIZE_W'(MAX_ENTRIES)) ? SIZE_W'(MAX_ENTRIES) : r_size;
    assign in_range = SIZE_W'(i_entry_index) < size_eff;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_idx    <= i_entry_index;
            r_ok     <= in_range;
            r_target <= i_color_in;
            r_n      <= CW'(size_eff);
        end
    end

    // palette store
    assign issue   = i_cmd.scan && (r_cnt < r_n) && (r_bestd != '0);
    assign rd_en   = i_cmd.mem_rd || issue;
    assign rd_addr = i_cmd.scan ? r_cnt[AW-1:0] : i_entry_index[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            mem[i_entry_index[AW-1:0]] <= i_color_in;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // scan: read of entry k overlaps compare of entry k-1
    assign cur_dist = color_dist(r_rd_data, r_target);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else if (i_cmd.start) begin
            r_pend <= 1'b0;
        end else if (i_cmd.scan) begin
            r_pend <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_cnt   <= '0;
            r_best  <= '0;
            r_bestd <= DIST_INIT;
        end else if (i_cmd.scan) begin
            if (issue) begin
                r_cnt      <= r_cnt + CW'(1);
                r_pend_idx <= r_cnt[AW-1:0];
            end
            if (r_pend && (cur_dist < r_bestd)) begin
                r_best  <= r_pend_idx;
                r_bestd <= cur_dist;
            end
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            if (i_cmd.out_find) begin
                r_out_idx   <= IDX_W'(r_best);
                r_out_color <= '0;
                r_out_ok    <= 1'b1;
            end else begin
                r_out_idx   <= r_idx;
                r_out_color <= r_ok ? r_rd_data : '0;
                r_out_ok    <= r_ok;
            end
        end
    end

    assign o_sts.in_range  = in_range;
    assign o_sts.scan_done = !r_pend && (!(r_cnt < r_n) || (r_bestd == '0));
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_best_index = r_out_idx;
    assign o_color_out  = r_out_color;
    assign o_valid_res  = r_out_ok;

endmodule

### hw/rtl/palette_nearest_color_unit.sv
// palette nearest colour unit
// request channel (i_req): mode, entry_index, color_in; one word per operation
//   write stores color_in at entry_index when the index is below the palette size
//   read returns the stored colour, or valid_res 0 when the index is out of range
//   find returns the lowest index of the entry with the smallest sum of absolute
//   red, green and blue differences to color_in
// result channel (o_res): best_index, color_out, valid_res; one word for read and find
// config channel (i_cfg): palette size, always ready, write it while the unit is idle
// a write or an unused mode gives no result
//   read: the entry is registered, then loaded into the output register once free
//   find: compares the n entries of the palette in turn, stopping early on an exact match;
//   the palette store has a single read port, and the scan reads one entry per cycle
// one operation is in flight at a time; a new request is taken once the result of
// the previous one is in the output register, even if that word is not yet taken
// when the receiver stalls, the finished word is held and the unit waits for it
// reset: palette size goes to 256 and the result register empties; the palette
// contents are undefined until written
`include "palette_nearest_color_unit_defines.svh"

module palette_nearest_color_unit #(
    parameter int MAX_ENTRIES = pnc_pkg::MAX_ENTRIES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pnc_req_if.sink   i_req,
    pnc_res_if.source o_res,
    pnc_cfg_if.sink   i_cfg
);
    import pnc_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign i_cfg.ready = 1'b1;

    pnc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_mode     (i_req.mode),
        .i_sts      (sts),
        .o_in_ready (i_req.ready),
        .o_cmd      (cmd)
    );

    pnc_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_valid   (i_cfg.valid),
        .i_cfg_data    (i_cfg.data),
        .i_entry_index (i_req.entry_index),
        .i_color_in    (i_req.color_in),
        .i_out_ready   (o_res.ready),
        .o_out_valid   (o_res.valid),
        .o_best_index  (o_res.best_index),
        .o_color_out   (o_res.color_out),
        .o_valid_res   (o_res.valid_res)
    );

    `PNC_ASSERT(a_load_when_free, cmd.load_out |-> sts.out_free)
    `PNC_ASSERT(a_write_on_accept, cmd.mem_wr |-> (cmd.accept && sts.in_range))
    `PNC_ASSERT(a_no_scan_after_done, cmd.scan |-> !sts.scan_done)
    `PNC_ASSERT_NEXT(a_load_shows_word, cmd.load_out, o_res.valid)

endmodule

### tb/palette_nearest_color_unit_tb.sv
module palette_nearest_color_unit_tb;
    import pnc_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int IDLE_PERCENT = 28;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_OFF_CYCLES = 300;

    typedef struct packed {
        logic [IDX_W-1:0]   best_index;
        logic [COLOR_W-1:0] color_out;
        logic               valid_res;
    } t_palette_result;

    logic i_clk;
    logic i_rst_n;

    pnc_req_if req_if();
    pnc_res_if res_if();
    pnc_cfg_if cfg_if();

    palette_nearest_color_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    logic [COLOR_W-1:0] palette_copy [256];
    logic [SIZE_W-1:0]  size_copy;
    t_palette_result    pending_results [$];

    int  mismatches;
    int  items_sent;
    int  results_checked;
    int  sizes_used;
    int  idle_cycles;
    int  res_hold_cycles;
    bit  calm_run;

    always #4 i_clk = ~i_clk;

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.mode = MODE_WRITE;
        req_if.entry_index = '0;
        req_if.color_in = '0;
        res_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.data = '0;
    end

    // receiver side: random back-pressure and long hold-offs
    always @(negedge i_clk) begin
        if (res_hold_cycles > 0) begin
            res_if.ready = 1'b0;
            res_hold_cycles--;
        end else begin
            res_if.ready = calm_run || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    function automatic int rgb_distance(input logic [COLOR_W-1:0] a,
                                        input logic [COLOR_W-1:0] b);
        int d;
        int x;
        int y;
        d = 0;
        for (int ch = 0; ch < 3; ch++) begin
            x = int'(a[ch*8 +: 8]);
            y = int'(b[ch*8 +: 8]);
            d += (x > y) ? (x - y) : (y - x);
        end
        return d;
    endfunction

    function automatic int entries_in_use();
        return (size_copy > 256) ? 256 : int'(size_copy);
    endfunction

    task automatic apply_palette_op(input logic [MODE_W-1:0] mode,
                                    input logic [IDX_W-1:0] idx,
                                    input logic [COLOR_W-1:0] color);
        int n;
        int best;
        int bestd;
        int d;
        t_palette_result r;
        n = entries_in_use();
        r = '0;
        case (mode)
            MODE_WRITE: begin
                if (idx < n) palette_copy[idx] = color;
            end
            MODE_READ: begin
                r.best_index = idx;
                r.color_out = (idx < n) ? palette_copy[idx] : '0;
                r.valid_res = (idx < n);
                pending_results.push_back(r);
            end
            MODE_FIND: begin
                best = 0;
                bestd = 32'h7fffffff;
                for (int i = 0; i < n && bestd != 0; i++) begin
                    d = rgb_distance(palette_copy[i], color);
                    if (d < bestd) begin
                        bestd = d;
                        best = i;
                    end
                end
                r.best_index = best[IDX_W-1:0];
                r.color_out = '0;
                r.valid_res = 1'b1;
                pending_results.push_back(r);
            end
            default: ;
        endcase
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_palette_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            results_checked++;
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected: best_index %0d", res_if.best_index);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (res_if.best_index !== want.best_index) begin
                    $error("best_index: expected %0d, got %0d", want.best_index,
                           res_if.best_index);
                    mismatches++;
                end
                if (res_if.color_out !== want.color_out) begin
                    $error("color_out: expected %06h, got %06h", want.color_out,
                           res_if.color_out);
                    mismatches++;
                end
                if (res_if.valid_res !== want.valid_res) begin
                    $error("valid_res: expected %0d, got %0d", want.valid_res,
                           res_if.valid_res);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)
                || (cfg_if.valid && cfg_if.ready) || !i_rst_n) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $error("no handshake for %0d cycles, %0d results outstanding", idle_cycles,
                   pending_results.size());
            $display("palette_nearest_color_unit_tb: FAIL");
            $finish;
        end
    end

    task automatic send_op(input logic [MODE_W-1:0] mode, input logic [IDX_W-1:0] idx,
                           input logic [COLOR_W-1:0] color);
        @(negedge i_clk);
        if (!calm_run) begin
            while ($urandom_range(99) < IDLE_PERCENT) begin
                req_if.valid = 1'b0;
                @(negedge i_clk);
            end
        end
        req_if.valid = 1'b1;
        req_if.mode = mode;
        req_if.entry_index = idx;
        req_if.color_in = color;
        do @(posedge i_clk); while (!req_if.ready);
        apply_palette_op(mode, idx, color);
        items_sent++;
    endtask

    task automatic wait_results_drained();
        @(negedge i_clk);
        req_if.valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_palette_size(input logic [SIZE_W-1:0] value);
        wait_results_drained();
        @(negedge i_clk);
        cfg_if.valid = 1'b1;
        cfg_if.data = value;
        do @(posedge i_clk); while (!cfg_if.ready);
        size_copy = value;
        sizes_used++;
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic send_random_op();
        int n;
        int pick;
        int j;
        logic [MODE_W-1:0]  mode;
        logic [IDX_W-1:0]   idx;
        logic [COLOR_W-1:0] color;
        n = entries_in_use();
        pick = $urandom_range(99);
        if (pick < 35) mode = MODE_WRITE;
        else if (pick < 65) mode = MODE_READ;
        else if (pick < 95) mode = MODE_FIND;
        else mode = MODE_UNUSED;
        if (n > 0 && $urandom_range(99) < 75) idx = IDX_W'($urandom_range(n - 1));
        else idx = IDX_W'($urandom_range(255));
        color = COLOR_W'($urandom_range(24'hFFFFFF));
        if (mode == MODE_FIND && n > 0) begin
            j = $urandom_range(n - 1);
            pick = $urandom_range(99);
            if (pick < 30) begin
                color = palette_copy[j];
            end else if (pick < 60) begin
                color = palette_copy[j] ^ COLOR_W'($urandom_range(7) << (8 * $urandom_range(2)));
            end
        end
        if (mode == MODE_WRITE && $urandom_range(99) < 10) begin
            color = $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
        end
        send_op(mode, idx, color);
    endtask

    task automatic test_fill_palette();
        set_palette_size(9'd256);
        for (int i = 0; i < 256; i++) begin
            if (i == 0) send_op(MODE_WRITE, 8'd0, 24'h000000);
            else if (i == 255) send_op(MODE_WRITE, 8'd255, 24'hFFFFFF);
            else send_op(MODE_WRITE, i[IDX_W-1:0], COLOR_W'($urandom_range(24'hFFFFFF)));
        end
    endtask

    task automatic test_directed_cases();
        set_palette_size(9'd4);
        send_op(MODE_WRITE, 8'd0, 24'h000010);
        send_op(MODE_WRITE, 8'd1, 24'h000020);
        send_op(MODE_WRITE, 8'd2, 24'h0000FF);
        send_op(MODE_WRITE, 8'd3, 24'h00FF00);
        // equal distance to entries 0 and 1
        send_op(MODE_FIND, 8'd0, 24'h000018);
        send_op(MODE_FIND, 8'hFF, 24'h000020);
        send_op(MODE_FIND, 8'd0, 24'hFFFFFF);
        send_op(MODE_FIND, 8'd0, 24'h000000);
        send_op(MODE_READ, 8'd3, 24'h000000);
        send_op(MODE_READ, 8'd4, 24'hFFFFFF);
        send_op(MODE_READ, 8'd255, 24'h000000);
        send_op(MODE_WRITE, 8'd10, 24'hABCDEF);
        send_op(MODE_UNUSED, 8'h5A, 24'h123456);
        send_op(MODE_UNUSED, 8'hFF, 24'hFFFFFF);
        set_palette_size(9'd0);
        send_op(MODE_FIND, 8'd0, 24'h808080);
        send_op(MODE_READ, 8'd0, 24'h000000);
        send_op(MODE_WRITE, 8'd0, 24'h555555);
        set_palette_size(9'd511);
        send_op(MODE_READ, 8'd10, 24'h000000);
        send_op(MODE_READ, 8'd255, 24'h000000);
        send_op(MODE_FIND, 8'd0, 24'hFFFFFF);
        send_op(MODE_FIND, 8'd0, 24'h7F00FE);
        set_palette_size(9'd1);
        send_op(MODE_FIND, 8'd0, 24'hFFFFFF);
        send_op(MODE_READ, 8'd0, 24'h000000);
        send_op(MODE_READ, 8'd1, 24'h000000);
    endtask

    task automatic test_result_hold_off();
        set_palette_size(9'd16);
        res_hold_cycles = HOLD_OFF_CYCLES;
        repeat (12) begin
            if ($urandom_range(1)) send_op(MODE_READ, IDX_W'($urandom_range(20)), 24'h000000);
            else send_op(MODE_FIND, 8'd0, COLOR_W'($urandom_range(24'hFFFFFF)));
        end
        wait_results_drained();
    endtask

    task automatic test_back_to_back();
        set_palette_size(9'd32);
        calm_run = 1'b1;
        repeat (60) send_random_op();
        wait_results_drained();
        calm_run = 1'b0;
    endtask

    task automatic test_random_sizes();
        logic [SIZE_W-1:0] sizes [9];
        sizes = '{9'd2, 9'd17, 9'd64, 9'd256, 9'd511, 9'd0, 9'd1, 9'd5, 9'd0};
        sizes[8] = SIZE_W'($urandom_range(511));
        foreach (sizes[k]) begin
            set_palette_size(sizes[k]);
            repeat (45) send_random_op();
        end
    endtask

    initial begin
        mismatches = 0;
        items_sent = 0;
        results_checked = 0;
        sizes_used = 0;
        idle_cycles = 0;
        res_hold_cycles = 0;
        calm_run = 1'b0;
        size_copy = 9'(SIZE_RESET);
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_fill_palette();
        test_directed_cases();
        test_result_hold_off();
        test_back_to_back();
        test_random_sizes();
        wait_results_drained();
        repeat (20) @(posedge i_clk);

        $display("covered %0d request words and %0d result words over %0d palette size writes",
                 items_sent, results_checked, sizes_used);
        $display("including a %0d cycle result hold-off and a run with no idling",
                 HOLD_OFF_CYCLES);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("palette_nearest_color_unit_tb: PASS");
        end else begin
            $display("palette_nearest_color_unit_tb: FAIL");
        end
        $finish;
    end

endmodule
